// ----- src/assert_macros.svh -----
// Assertion macros for the checker module tcw_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int CMD_W       = 3;
    localparam int CHAR_W      = 8;
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;
    localparam int LOC_FIELD_W = 11;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = ATTR_W + CHAR_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_CELL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_CELL  = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    // Register slot selected by paddr[2].
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [CHAR_W-1:0]      char_code;
        logic [COL_FIELD_W-1:0] column;
        logic [ROW_FIELD_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] cursor_column;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [LOC_FIELD_W-1:0] cursor_location;
        logic [CHAR_W-1:0]      read_char;
        logic [ATTR_W-1:0]      read_attribute;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_TAB_MUL,
        S_TAB_REM,
        S_TAB_STEP,
        S_SCROLL,
        S_FILL,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

// ----- src/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/text_console_writer.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_item  (tcw_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_item (tcw_pkg::t_out_item)
// config    in         psel / penable / pready    paddr, pwdata, prdata
//
// Set cursor, positioned write, read, unknown commands and non-tab puts that do not
// scroll go from S_IDLE to S_DONE. A tab passes S_TAB_MUL and S_TAB_REM, then S_TAB_STEP
// moves one cell per step (at most TAB_STOP cells). Scroll and clear sweep the
// single-port-write cell RAM, one cell per cycle. After reset a clearing pass in
// S_INIT zeroes the RAM; o_in_stall stays high through it and its last write. A result
// waiting on i_out_stall holds the block in S_DONE; the next item is then taken.

module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  tcw_pkg::t_in_item                    i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output tcw_pkg::t_out_item                   o_out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int CELLS         = COLUMNS * ROWS;
    localparam int ADDR_W        = $clog2(CELLS);
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int ROW_W         = $clog2(ROWS);
    localparam int STEP_W        = $clog2(TAB_STOP + 1);
    localparam int TAB_SH        = ADDR_W + 5;
    localparam int TAB_RECIP     = (1 << TAB_SH) / TAB_STOP + 1;
    localparam int RECIP_W       = TAB_SH + 1;
    localparam int PROD_W        = ADDR_W + RECIP_W;
    localparam int LAST_CELL     = CELLS - 1;
    localparam int LAST_ROW_BASE = CELLS - COLUMNS;

    tcw_pkg::t_state r_state, n_state;

    logic [COL_W-1:0]            r_col, n_col;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [ADDR_W-1:0]           r_loc, n_loc;
    logic [tcw_pkg::ATTR_W-1:0]  r_attr;
    logic [ADDR_W-1:0]           r_idx, n_idx;
    logic [STEP_W-1:0]           r_steps, n_steps;
    logic [PROD_W-1:0]           r_prod, n_prod;
    logic [ADDR_W-1:0]           r_rd_addr, n_rd_addr;
    logic                        r_rd_en, n_rd_en;
    logic                        r_wr_en, n_wr_en;
    logic [ADDR_W-1:0]           r_wr_addr, n_wr_addr;
    logic                        r_wr_from_mem, n_wr_from_mem;
    logic [tcw_pkg::CELL_W-1:0]  r_wr_data, n_wr_data;
    logic                        r_out_valid, n_out_valid;
    tcw_pkg::t_out_item          r_out, n_out;

    logic                        in_accept;
    logic                        out_room;
    logic                        cfg_write;
    logic [31:0]                 in_col32;
    logic [31:0]                 in_row32;
    logic                        in_inside;
    logic [ADDR_W-1:0]           in_addr;
    logic [COL_W-1:0]            set_col;
    logic [ROW_W-1:0]            set_row;
    logic [ADDR_W-1:0]           set_loc;
    logic                        col_last;
    logic                        row_last;
    logic                        at_last;
    logic [COL_W-1:0]            adv_col;
    logic [ROW_W-1:0]            adv_row;
    logic [ADDR_W-1:0]           tab_q;
    logic [ADDR_W-1:0]           tab_rem;
    logic [tcw_pkg::CELL_W-1:0]  blank_cell;
    logic [31:0]                 out_col32;
    logic [31:0]                 out_row32;
    logic [31:0]                 out_loc32;

    logic [ADDR_W-1:0]           ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;

    assign in_accept = (r_state == tcw_pkg::S_IDLE) && !r_wr_en && i_in_valid;
    assign o_in_stall = (r_state != tcw_pkg::S_IDLE) || r_wr_en;
    assign out_room = !r_out_valid || !i_out_stall;

    assign in_col32  = 32'(i_in_item.column);
    assign in_row32  = 32'(i_in_item.row);
    assign in_inside = (in_col32 < COLUMNS) && (in_row32 < ROWS);
    assign in_addr   = ADDR_W'(in_row32 * COLUMNS + in_col32);
    assign set_col   = (in_col32 > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(in_col32);
    assign set_row   = (in_row32 > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(in_row32);
    assign set_loc   = ADDR_W'(32'(set_row) * COLUMNS + 32'(set_col));

    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign at_last  = (r_loc == ADDR_W'(LAST_CELL));
    assign adv_col  = col_last ? '0 : r_col + COL_W'(1);
    assign adv_row  = col_last ? r_row + ROW_W'(1) : r_row;

    assign tab_q   = r_prod[TAB_SH +: ADDR_W];
    assign tab_rem = r_loc - ADDR_W'(32'(tab_q) * TAB_STOP);

    assign blank_cell = {r_attr, tcw_pkg::CHAR_SPACE};

    assign out_col32 = 32'(r_col);
    assign out_row32 = 32'(r_row);
    assign out_loc32 = 32'(r_loc);

    assign ram_raddr = (r_state == tcw_pkg::S_SCROLL) ? r_idx + ADDR_W'(COLUMNS) :
                       (r_state == tcw_pkg::S_IDLE) ? in_addr : r_rd_addr;
    assign ram_wdata = r_wr_from_mem ? ram_rdata : r_wr_data;

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (r_wr_en),
        .i_waddr(r_wr_addr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign cfg_write = psel && penable && pwrite && (paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE) ?
                    tcw_pkg::APB_DATA_W'(r_attr) : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            tcw_pkg::S_INIT: begin
                if (r_idx == ADDR_W'(LAST_CELL)) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = tcw_pkg::S_DONE;
                    unique case (i_in_item.command)
                        tcw_pkg::CMD_PUT_CHAR: begin
                            if (i_in_item.char_code == tcw_pkg::CHAR_TAB) begin
                                n_state = tcw_pkg::S_TAB_MUL;
                            end else if (i_in_item.char_code == tcw_pkg::CHAR_NEWLINE) begin
                                if (row_last) begin
                                    n_state = tcw_pkg::S_SCROLL;
                                end
                            end else if (at_last) begin
                                n_state = tcw_pkg::S_SCROLL;
                            end
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            n_state = tcw_pkg::S_CLEAR;
                        end
                        default: begin
                            n_state = tcw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            tcw_pkg::S_TAB_MUL: begin
                n_state = tcw_pkg::S_TAB_REM;
            end
            tcw_pkg::S_TAB_REM: begin
                n_state = tcw_pkg::S_TAB_STEP;
            end
            tcw_pkg::S_TAB_STEP: begin
                if (at_last) begin
                    n_state = tcw_pkg::S_SCROLL;
                end else if (r_steps == STEP_W'(1)) begin
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_SCROLL: begin
                if (r_idx == ADDR_W'(LAST_ROW_BASE - 1)) begin
                    n_state = tcw_pkg::S_FILL;
                end
            end
            tcw_pkg::S_FILL, tcw_pkg::S_CLEAR: begin
                if (r_idx == ADDR_W'(LAST_CELL)) begin
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_DONE: begin
                if (out_room) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_col         = r_col;
        n_row         = r_row;
        n_loc         = r_loc;
        n_idx         = r_idx;
        n_steps       = r_steps;
        n_prod        = r_prod;
        n_rd_addr     = r_rd_addr;
        n_rd_en       = r_rd_en;
        n_wr_en       = 1'b0;
        n_wr_addr     = r_wr_addr;
        n_wr_from_mem = 1'b0;
        n_wr_data     = r_wr_data;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;

        unique case (r_state)
            tcw_pkg::S_INIT: begin
                n_wr_en   = 1'b1;
                n_wr_addr = r_idx;
                n_wr_data = '0;
                n_idx     = r_idx + ADDR_W'(1);
            end
            tcw_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_rd_addr = in_addr;
                    n_rd_en   = (i_in_item.command == tcw_pkg::CMD_READ_CELL) && in_inside;
                    n_idx     = '0;
                    unique case (i_in_item.command)
                        tcw_pkg::CMD_PUT_CHAR: begin
                            if (i_in_item.char_code == tcw_pkg::CHAR_NEWLINE) begin
                                if (!row_last) begin
                                    n_col = '0;
                                    n_row = r_row + ROW_W'(1);
                                    n_loc = r_loc + ADDR_W'(COLUMNS) - ADDR_W'(r_col);
                                end
                            end else if (i_in_item.char_code != tcw_pkg::CHAR_TAB) begin
                                n_wr_en   = 1'b1;
                                n_wr_addr = r_loc;
                                n_wr_data = {r_attr, i_in_item.char_code};
                                if (!at_last) begin
                                    n_col = adv_col;
                                    n_row = adv_row;
                                    n_loc = r_loc + ADDR_W'(1);
                                end
                            end
                        end
                        tcw_pkg::CMD_SET_CURSOR: begin
                            n_col = set_col;
                            n_row = set_row;
                            n_loc = set_loc;
                        end
                        tcw_pkg::CMD_WRITE_CELL: begin
                            n_wr_en   = in_inside;
                            n_wr_addr = in_addr;
                            n_wr_data = {r_attr, i_in_item.char_code};
                        end
                        default: begin
                            n_idx = '0;
                        end
                    endcase
                end
            end
            tcw_pkg::S_TAB_MUL: begin
                n_prod = PROD_W'(r_loc) * PROD_W'(TAB_RECIP);
            end
            tcw_pkg::S_TAB_REM: begin
                n_steps = STEP_W'(TAB_STOP) - STEP_W'(tab_rem);
            end
            tcw_pkg::S_TAB_STEP: begin
                n_steps = r_steps - STEP_W'(1);
                if (!at_last) begin
                    n_col = adv_col;
                    n_row = adv_row;
                    n_loc = r_loc + ADDR_W'(1);
                end
            end
            tcw_pkg::S_SCROLL: begin
                n_wr_en       = 1'b1;
                n_wr_addr     = r_idx;
                n_wr_from_mem = 1'b1;
                n_idx         = r_idx + ADDR_W'(1);
                n_col         = '0;
                n_row         = ROW_W'(ROWS - 1);
                n_loc         = ADDR_W'(LAST_ROW_BASE);
            end
            tcw_pkg::S_FILL: begin
                n_wr_en   = 1'b1;
                n_wr_addr = r_idx;
                n_wr_data = blank_cell;
                n_idx     = r_idx + ADDR_W'(1);
            end
            tcw_pkg::S_CLEAR: begin
                n_wr_en   = 1'b1;
                n_wr_addr = r_idx;
                n_wr_data = blank_cell;
                n_idx     = r_idx + ADDR_W'(1);
                n_col     = '0;
                n_row     = '0;
                n_loc     = '0;
            end
            tcw_pkg::S_DONE: begin
                if (out_room) begin
                    n_out_valid           = 1'b1;
                    n_out.cursor_column   = out_col32[tcw_pkg::COL_FIELD_W-1:0];
                    n_out.cursor_row      = out_row32[tcw_pkg::ROW_FIELD_W-1:0];
                    n_out.cursor_location = out_loc32[tcw_pkg::LOC_FIELD_W-1:0];
                    n_out.read_char       = r_rd_en ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
                    n_out.read_attribute  = r_rd_en ?
                                            ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
                end
            end
            default: begin
                n_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_loc       <= '0;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_idx       <= '0;
            r_rd_en     <= 1'b0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_loc       <= n_loc;
            r_idx       <= n_idx;
            r_rd_en     <= n_rd_en;
            r_wr_en     <= n_wr_en;
            r_out_valid <= n_out_valid;
            if (cfg_write) begin
                r_attr <= pwdata[tcw_pkg::ATTR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps       <= n_steps;
        r_prod        <= n_prod;
        r_rd_addr     <= n_rd_addr;
        r_wr_addr     <= n_wr_addr;
        r_wr_from_mem <= n_wr_from_mem;
        r_wr_data     <= n_wr_data;
        r_out         <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- src/tcw_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tcw_pkg::t_out_item o_out_item
);

    localparam bit CHECK_LOC = (COLUMNS * ROWS <= 2048) && (COLUMNS <= 128);

    logic        in_acc;
    logic [31:0] exp_loc;
    logic [31:0] got_loc;
    logic [31:0] got_col;
    logic [31:0] got_row;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign got_col = 32'(o_out_item.cursor_column);
    assign got_row = 32'(o_out_item.cursor_row);
    assign got_loc = 32'(o_out_item.cursor_location);
    assign exp_loc = got_row * COLUMNS + got_col;

    `TCW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "Stalled result item changed.")
    `TCW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "Item accepted while the previous one was still in work.")
    `TCW_ASSERT_SAME(a_cursor_range, i_clk, i_rst_n, o_out_valid, (got_col < COLUMNS) && (got_row < ROWS), "Reported cursor lies outside the screen.")
    `TCW_ASSERT_SAME(a_cursor_loc, i_clk, i_rst_n, CHECK_LOC && o_out_valid, got_loc == exp_loc, "Cursor location disagrees with column and row.")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (.*);

// ----- verif/tcw_checker.sv -----
`timescale 1ns / 1ps

module tcw_scoreboard #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  tcw_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  tcw_pkg::t_out_item             i_out_item,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [tcw_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_scrolls
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic [tcw_pkg::CELL_W-1:0] screen [CELL_COUNT];
    int unsigned                cursor_pos;
    logic [tcw_pkg::ATTR_W-1:0] attribute;
    tcw_pkg::t_out_item         cursor_results_q[$];
    tcw_pkg::t_out_item         want;
    int                         fail_total = 0;
    int                         scroll_total = 0;

    assign o_fail_count = fail_total;
    assign o_scrolls    = scroll_total;

    function automatic void blank_cells(int unsigned from, int unsigned to);
        for (int unsigned i = from; i < to; i++) begin
            screen[i] = {attribute, tcw_pkg::CHAR_SPACE};
        end
    endfunction

    function automatic tcw_pkg::t_out_item console_step(tcw_pkg::t_in_item item);
        tcw_pkg::t_out_item res;
        int unsigned        col;
        int unsigned        row;
        logic               on_screen;
        col = 32'(item.column);
        row = 32'(item.row);
        on_screen = (col < COLUMNS) && (row < ROWS);
        res = '0;
        case (item.command)
            tcw_pkg::CMD_PUT_CHAR: begin
                if (item.char_code == tcw_pkg::CHAR_NEWLINE) begin
                    cursor_pos += COLUMNS - (cursor_pos % COLUMNS);
                end else if (item.char_code == tcw_pkg::CHAR_TAB) begin
                    cursor_pos += TAB_STOP - (cursor_pos % TAB_STOP);
                end else begin
                    screen[cursor_pos] = {attribute, item.char_code};
                    cursor_pos++;
                end
                if (cursor_pos >= CELL_COUNT) begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                        screen[i] = screen[i + COLUMNS];
                    end
                    blank_cells(CELL_COUNT - COLUMNS, CELL_COUNT);
                    cursor_pos = CELL_COUNT - COLUMNS;
                    scroll_total++;
                end
            end
            tcw_pkg::CMD_SET_CURSOR: begin
                if (col > COLUMNS - 1) begin
                    col = COLUMNS - 1;
                end
                if (row > ROWS - 1) begin
                    row = ROWS - 1;
                end
                cursor_pos = row * COLUMNS + col;
            end
            tcw_pkg::CMD_CLEAR: begin
                blank_cells(0, CELL_COUNT);
                cursor_pos = 0;
            end
            tcw_pkg::CMD_WRITE_CELL: begin
                if (on_screen) begin
                    screen[row * COLUMNS + col] = {attribute, item.char_code};
                end
            end
            tcw_pkg::CMD_READ_CELL: begin
                if (on_screen) begin
                    res.read_char      = screen[row * COLUMNS + col][tcw_pkg::CHAR_W-1:0];
                    res.read_attribute =
                        screen[row * COLUMNS + col][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end
            end
            default: begin
            end
        endcase
        res.cursor_column   = tcw_pkg::COL_FIELD_W'(cursor_pos % COLUMNS);
        res.cursor_row      = tcw_pkg::ROW_FIELD_W'(cursor_pos / COLUMNS);
        res.cursor_location = tcw_pkg::LOC_FIELD_W'(cursor_pos);
        return res;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_val,
                                        logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                screen[i] = '0;
            end
            cursor_pos = 0;
            attribute = tcw_pkg::ATTR_RESET;
            cursor_results_q.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE) begin
                attribute = i_pwdata[tcw_pkg::ATTR_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (cursor_results_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %p",
                             $time, i_out_item);
                    fail_total++;
                end else begin
                    want = cursor_results_q.pop_front();
                    check_field("cursor_column", 16'(want.cursor_column),
                                16'(i_out_item.cursor_column));
                    check_field("cursor_row", 16'(want.cursor_row),
                                16'(i_out_item.cursor_row));
                    check_field("cursor_location", 16'(want.cursor_location),
                                16'(i_out_item.cursor_location));
                    check_field("read_char", 16'(want.read_char),
                                16'(i_out_item.read_char));
                    check_field("read_attribute", 16'(want.read_attribute),
                                16'(i_out_item.read_attribute));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                cursor_results_q.push_back(console_step(i_in_item));
            end
            o_pending <= cursor_results_q.size();
        end
    end

endmodule

// ----- verif/tb_text_console_writer.sv -----
`timescale 1ns / 1ps

module tb_text_console_writer;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_STOP     = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 172;
    localparam int DRAIN_CYCLES = 50;
    localparam int LIMIT_CYCLES = 8_000_000;

    localparam logic [tcw_pkg::CMD_W-1:0]      CMD_UNUSED_FIRST    = 3'd5;
    localparam logic [tcw_pkg::CMD_W-1:0]      CMD_UNUSED_MID      = 3'd6;
    localparam logic [tcw_pkg::CMD_W-1:0]      CMD_UNUSED_LAST     = 3'd7;
    localparam logic [tcw_pkg::APB_ADDR_W-1:0] ADDR_TEXT_ATTRIBUTE =
        {tcw_pkg::REG_TEXT_ATTRIBUTE, 2'b00};

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    tcw_pkg::t_in_item              in_item   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    tcw_pkg::t_out_item             out_item;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [tcw_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [tcw_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [tcw_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int          fail_count;
    int          pending;
    int          scrolls;
    logic        gaps_on = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    int          cmd_count [8] = '{default: 0};
    int          newline_count = 0;
    int          tab_count = 0;
    int          attr_writes = 0;

    always #10 clk = ~clk;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .TAB_STOP(TAB_STOP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tcw_scoreboard #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .TAB_STOP(TAB_STOP)
    ) u_scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_scrolls   (scrolls)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d items outstanding.", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic tcw_pkg::t_in_item make_item(logic [tcw_pkg::CMD_W-1:0] cmd,
                                                    logic [tcw_pkg::CHAR_W-1:0] ch,
                                                    int unsigned col, int unsigned row);
        tcw_pkg::t_in_item item;
        item.command   = cmd;
        item.char_code = ch;
        item.column    = tcw_pkg::COL_FIELD_W'(col);
        item.row       = tcw_pkg::ROW_FIELD_W'(row);
        return item;
    endfunction

    function automatic tcw_pkg::t_in_item random_item();
        tcw_pkg::t_in_item item;
        int unsigned       pick;
        item.char_code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        item.column = tcw_pkg::COL_FIELD_W'(($urandom_range(0, 9) == 0) ?
                                            $urandom_range(0, 127) : $urandom_range(0, 79));
        item.row = tcw_pkg::ROW_FIELD_W'(($urandom_range(0, 9) == 0) ?
                                         $urandom_range(0, 31) : $urandom_range(0, 24));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            item.command = tcw_pkg::CMD_PUT_CHAR;
            if (pick < 4) begin
                item.char_code = tcw_pkg::CHAR_NEWLINE;
            end else if (pick < 8) begin
                item.char_code = tcw_pkg::CHAR_TAB;
            end
        end else if (pick < 67) begin
            item.command = tcw_pkg::CMD_SET_CURSOR;
            if ($urandom_range(0, 4) == 0) begin
                item.row = tcw_pkg::ROW_FIELD_W'($urandom_range(ROWS - 2, 31));
            end
        end else if (pick < 78) begin
            item.command = tcw_pkg::CMD_WRITE_CELL;
        end else if (pick < 96) begin
            item.command = tcw_pkg::CMD_READ_CELL;
        end else if (pick < 97) begin
            item.command = tcw_pkg::CMD_CLEAR;
        end else begin
            item.command = tcw_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end
        return item;
    endfunction

    task automatic send_item(input tcw_pkg::t_in_item item);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge clk); while (in_stall);
        cmd_count[item.command]++;
        if (item.command == tcw_pkg::CMD_PUT_CHAR &&
            item.char_code == tcw_pkg::CHAR_NEWLINE) begin
            newline_count++;
        end
        if (item.command == tcw_pkg::CMD_PUT_CHAR && item.char_code == tcw_pkg::CHAR_TAB) begin
            tab_count++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TEXT_ATTRIBUTE;
        pwdata <= tcw_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        attr_writes++;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        gaps_on <= 1'b1;

        // Reset contents and attribute, then ordinary puts, tab and newline.
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 0, 0));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, 8'h41, 0, 0));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, 8'h00, 127, 31));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, 8'hFF, 0, 0));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_TAB, 0, 0));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_NEWLINE, 0, 0));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 0, 0));
        // Positioned writes and reads at the last cell and off the screen.
        send_item(make_item(tcw_pkg::CMD_WRITE_CELL, 8'h5A, 79, 24));
        send_item(make_item(tcw_pkg::CMD_WRITE_CELL, 8'hA5, 80, 0));
        send_item(make_item(tcw_pkg::CMD_WRITE_CELL, 8'hA5, 127, 31));
        send_item(make_item(tcw_pkg::CMD_WRITE_CELL, 8'hA5, 0, 25));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 79, 24));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 80, 0));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 127, 31));
        // Saturating cursor, then scrolls caused by a character, a tab and a newline.
        send_item(make_item(tcw_pkg::CMD_SET_CURSOR, 8'h00, 127, 31));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, 8'h78, 0, 0));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 79, 23));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 0, 24));
        send_item(make_item(tcw_pkg::CMD_SET_CURSOR, 8'h00, 76, 24));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_TAB, 0, 0));
        send_item(make_item(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5, 24));
        send_item(make_item(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_NEWLINE, 0, 0));
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
            send_item(make_item(tcw_pkg::CMD_W'(c), tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                                $urandom_range(0, 127), $urandom_range(0, 31)));
        end
        send_item(make_item(tcw_pkg::CMD_CLEAR, 8'h00, 0, 0));
        send_item(make_item(tcw_pkg::CMD_READ_CELL, 8'h00, 10, 10));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 0) begin
                write_attribute(8'h00);
            end else if (p == 1) begin
                write_attribute(8'hFF);
            end else begin
                write_attribute(tcw_pkg::ATTR_W'($urandom_range(0, 255)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gaps_on <= (p != PHASES - 1) && !(n >= 60 && n < 90);
                send_item(random_item());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Items: %0d puts (%0d newlines, %0d tabs), %0d cursor moves, %0d clears,",
                 cmd_count[tcw_pkg::CMD_PUT_CHAR], newline_count, tab_count,
                 cmd_count[tcw_pkg::CMD_SET_CURSOR], cmd_count[tcw_pkg::CMD_CLEAR]);
        $display("%0d cell writes, %0d reads, %0d unused codes; %0d scrolls, %0d attributes.",
                 cmd_count[tcw_pkg::CMD_WRITE_CELL], cmd_count[tcw_pkg::CMD_READ_CELL],
                 cmd_count[CMD_UNUSED_FIRST] + cmd_count[CMD_UNUSED_MID] +
                 cmd_count[CMD_UNUSED_LAST], scrolls, attr_writes + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
